// ===== hdl/ntcbt_pkg.sv =====
package ntcbt_pkg;

    // Field and register widths
    localparam int OHMS_W     = 20;
    localparam int BETA_W     = 16;
    localparam int REF_TEMP_W = 12;
    localparam int MV_W       = 14;
    localparam int ADC_W      = 15;
    localparam int TEMP_W     = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // 4.096 V over the full scale: one count is 4096 mV / 2^ADC_BITS
    localparam int MEAS_SHIFT = 12;

    // log2 mantissa and fraction
    localparam int MANT_W    = 31;
    localparam int FRAC_BITS = 24;

    // ln(2) in Q0.32
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // Reference temperature in hundredths of kelvin: 27315 + 10 * T0
    localparam int K_W = 16;
    localparam logic signed [K_W:0] K_OFFSET = 17'sd27315;
    localparam logic signed [K_W:0] K_SCALE  = 17'sd10;

    // 100 << 32, numerator of the reference reciprocal
    localparam int REC_DVD_W = 39;
    localparam int REC_Q_W   = 26;
    localparam logic [REC_DVD_W-1:0] RECIP0_NUM = 39'd429496729600;

    // 1000 << 32, numerator of kelvin in thousandths
    localparam int Y_NUM_W = 42;
    localparam logic [Y_NUM_W-1:0] Y_NUM = 42'd4294967296000;

    // Kelvin thousandths in range fit in this many quotient bits
    localparam int Y_BITS = 19;
    localparam logic [Y_BITS-1:0] Y_HIGH = 19'd358150;
    localparam logic [Y_BITS-1:0] Y_LOW  = 19'd233150;
    localparam logic [Y_BITS-1:0] Y_BIAS = 19'd233100;

    // Divide by 100 through a reciprocal, exact below 2^17
    localparam int X_W            = 17;
    localparam int DIV100_MUL_W   = 18;
    localparam int DIV100_SHIFT   = 24;
    localparam int QT_W           = X_W + DIV100_MUL_W - DIV100_SHIFT;
    localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 18'd167773;
    localparam logic signed [QT_W:0] TENTHS_BIAS = 12'sd400;

    localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -11'sd400;
    localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 11'sd850;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NOMINAL  = 3'd0,
        REG_SHUNT    = 3'd1,
        REG_BETA     = 3'd2,
        REG_REF_TEMP = 3'd3,
        REG_DRIVE    = 3'd4
    } cfg_reg_t;

    // Outcome decided ahead of the final stage
    typedef enum logic [1:0] {
        FORCE_NONE,
        FORCE_LOW,
        FORCE_HIGH,
        FORCE_INVALID
    } force_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic                     lo;
        logic                     hi;
        logic                     inv;
    } result_t;

endpackage

// ===== hdl/ntc_beta_temperature_converter.sv =====
// NTC thermistor converter: one raw ADC count in, one temperature in tenths of a degree
// Celsius out (-40.0..85.0 C, rounded, with clamp and invalid-divider flags). A new count
// is taken every cycle while in_stall is low. A count passes through the 24 squaring
// stages of the two log2 units, the bit-per-stage divider by beta and the 19 stages of
// the final reciprocal. After reset and after each write of ref_temp_tenths the block
// holds in_stall high while an iterative divider forms the reference reciprocal.
// Configuration is taken any time (cfg_ready is always high) but must only change while
// no count is in flight. A finished result waits in an output register with one skid
// entry behind it.
module ntc_beta_temperature_converter #(
    parameter int ADC_BITS = 15
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic [ntcbt_pkg::ADC_W-1:0]              adc_count,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [ntcbt_pkg::TEMP_W-1:0]      temp_tenths,
    output logic                                     clamped_low,
    output logic                                     clamped_high,
    output logic                                     invalid_divider,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [ntcbt_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [ntcbt_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int RAW_W   = ADC_BITS;
    localparam int MEAS_W  = RAW_W + ntcbt_pkg::MEAS_SHIFT;
    localparam int DRIVE_W = ntcbt_pkg::MV_W + RAW_W;
    localparam int LW      = DRIVE_W + ntcbt_pkg::OHMS_W;
    localparam int PW      = $clog2(LW);
    localparam int MAG_W   = PW + ntcbt_pkg::FRAC_BITS;
    localparam int DVD_W   = MAG_W + 9;
    localparam int SUM_W   = DVD_W + 2;
    localparam int DIVS_W  = SUM_W - 1;
    localparam int YD_W    = ((DIVS_W > ntcbt_pkg::Y_NUM_W) ? DIVS_W : ntcbt_pkg::Y_NUM_W) + 1;
    localparam int FB      = ntcbt_pkg::FRAC_BITS;
    localparam int MW      = ntcbt_pkg::MANT_W;
    localparam int BW      = ntcbt_pkg::BETA_W;
    localparam int YB      = ntcbt_pkg::Y_BITS;
    localparam int RC_CNT_W = $clog2(ntcbt_pkg::REC_DVD_W + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ntcbt_pkg::OHMS_W-1:0]            nominal_reg;
    logic [ntcbt_pkg::OHMS_W-1:0]            shunt_reg;
    logic [BW-1:0]                           beta_reg;
    logic signed [ntcbt_pkg::REF_TEMP_W-1:0] ref_temp_reg;
    logic [ntcbt_pkg::MV_W-1:0]              drive_reg;
    logic                                    cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Latch written register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nominal_reg  <= 20'd10000;
            shunt_reg    <= 20'd10000;
            beta_reg     <= 16'd3435;
            ref_temp_reg <= 12'sd250;
            drive_reg    <= 14'd4000;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ntcbt_pkg::REG_NOMINAL:  nominal_reg  <= cfg_data;
                ntcbt_pkg::REG_SHUNT:    shunt_reg    <= cfg_data;
                ntcbt_pkg::REG_BETA:     beta_reg     <= cfg_data[BW-1:0];
                ntcbt_pkg::REG_REF_TEMP: ref_temp_reg <= cfg_data[ntcbt_pkg::REF_TEMP_W-1:0];
                ntcbt_pkg::REG_DRIVE:    drive_reg    <= cfg_data[ntcbt_pkg::MV_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Reference reciprocal: (100 << 32 + K0/2) / K0, one bit per cycle
    // ------------------------------------------------------------------
    logic                                   rc_start_reg, rc_start_next;
    logic [RC_CNT_W-1:0]                    rc_count_reg, rc_count_next;
    logic [ntcbt_pkg::REC_DVD_W-1:0]        rc_dvd_reg, rc_dvd_next;
    logic [ntcbt_pkg::K_W-1:0]              rc_k_reg, rc_k_next;
    logic [ntcbt_pkg::K_W-1:0]              rc_rem_reg, rc_rem_next;
    logic [ntcbt_pkg::REC_Q_W-1:0]          rc_q_reg, rc_q_next;
    logic signed [ntcbt_pkg::K_W:0]         rc_k_wide;
    logic [ntcbt_pkg::K_W:0]                rc_r;
    logic                                   rc_ge;
    logic                                   rc_busy;

    always_comb
    begin
        rc_k_wide     = ntcbt_pkg::K_OFFSET
                      + (17)'(ref_temp_reg) * ntcbt_pkg::K_SCALE;
        rc_r          = {rc_rem_reg, rc_dvd_reg[ntcbt_pkg::REC_DVD_W-1]};
        rc_ge         = rc_r >= {1'b0, rc_k_reg};
        rc_start_next = cfg_write && (cfg_index == ntcbt_pkg::REG_REF_TEMP);
        rc_count_next = rc_count_reg;
        rc_dvd_next   = rc_dvd_reg;
        rc_k_next     = rc_k_reg;
        rc_rem_next   = rc_rem_reg;
        rc_q_next     = rc_q_reg;
        if (rc_start_reg)
        begin
            // Load dividend with rounding term
            rc_k_next     = rc_k_wide[ntcbt_pkg::K_W-1:0];
            rc_dvd_next   = ntcbt_pkg::RECIP0_NUM
                          + ntcbt_pkg::REC_DVD_W'(rc_k_wide[ntcbt_pkg::K_W-1:1]);
            rc_rem_next   = '0;
            rc_q_next     = '0;
            rc_count_next = RC_CNT_W'(ntcbt_pkg::REC_DVD_W);
        end
        else if (rc_count_reg != '0)
        begin
            // Shift in one dividend bit, subtract when it fits
            rc_rem_next   = rc_ge ? ntcbt_pkg::K_W'(rc_r - {1'b0, rc_k_reg})
                                  : ntcbt_pkg::K_W'(rc_r);
            rc_dvd_next   = rc_dvd_reg << 1;
            rc_q_next     = {rc_q_reg[ntcbt_pkg::REC_Q_W-2:0], rc_ge};
            rc_count_next = rc_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_start_reg <= 1'b1;
            rc_count_reg <= '0;
        end
        else
        begin
            rc_start_reg <= rc_start_next;
            rc_count_reg <= rc_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rc_dvd_reg <= rc_dvd_next;
        rc_k_reg   <= rc_k_next;
        rc_rem_reg <= rc_rem_next;
        rc_q_reg   <= rc_q_next;
    end

    assign rc_busy = rc_start_reg || (rc_count_reg != '0);

    // ------------------------------------------------------------------
    // Pipeline advance: the whole pipe moves while the skid entry is free
    // ------------------------------------------------------------------
    logic skid_full_reg, skid_full_next;
    logic adv;
    logic in_take;

    assign adv      = !skid_full_reg;
    assign in_stall = skid_full_reg || rc_busy;
    assign in_take  = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Stage 1: compare voltages, classify special cases
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]       raw;
    logic [DRIVE_W-1:0]     meas_ext;
    logic [DRIVE_W-1:0]     drive_full;
    ntcbt_pkg::force_t      s1_kind_next;

    logic                   s1_valid_reg;
    ntcbt_pkg::force_t      s1_kind_reg;
    logic [DRIVE_W-1:0]     s1_diff_reg;
    logic [MEAS_W-1:0]      s1_meas_reg;

    always_comb
    begin
        raw        = RAW_W'(adc_count);
        meas_ext   = DRIVE_W'({raw, {ntcbt_pkg::MEAS_SHIFT{1'b0}}});
        drive_full = {drive_reg, {RAW_W{1'b0}}};
        if (raw == '0)
            s1_kind_next = ntcbt_pkg::FORCE_LOW;
        else if (meas_ext >= drive_full)
            s1_kind_next = ntcbt_pkg::FORCE_INVALID;
        else if (shunt_reg == '0 || nominal_reg == '0 || beta_reg == '0)
            s1_kind_next = ntcbt_pkg::FORCE_LOW;
        else
            s1_kind_next = ntcbt_pkg::FORCE_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_kind_reg <= s1_kind_next;
            s1_diff_reg <= drive_full - meas_ext;
            s1_meas_reg <= MEAS_W'(meas_ext);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: numerator and denominator of the resistance ratio
    // ------------------------------------------------------------------
    logic                   s2_valid_reg;
    ntcbt_pkg::force_t      s2_kind_reg;
    logic [LW-1:0]          s2_num_reg;
    logic [LW-1:0]          s2_den_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_num_reg  <= LW'(s1_diff_reg) * LW'(shunt_reg);
            s2_den_reg  <= LW'(s1_meas_reg) * LW'(nominal_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: leading-one position (integer part of log2)
    // ------------------------------------------------------------------
    function automatic logic [PW-1:0] msb_pos(input logic [LW-1:0] v);
        logic [PW-1:0] pos;
        pos = '0;
        for (int i = 0; i < LW; i++)
        begin
            if (v[i])
                pos = PW'(i);
        end
        return pos;
    endfunction

    logic                   s3_valid_reg;
    ntcbt_pkg::force_t      s3_kind_reg;
    logic [LW-1:0]          s3_num_reg;
    logic [LW-1:0]          s3_den_reg;
    logic [PW-1:0]          s3_pn_reg;
    logic [PW-1:0]          s3_pd_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_kind_reg <= s2_kind_reg;
            s3_num_reg  <= s2_num_reg;
            s3_den_reg  <= s2_den_reg;
            s3_pn_reg   <= msb_pos(s2_num_reg);
            s3_pd_reg   <= msb_pos(s2_den_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: normalize to a Q1.30 mantissa
    // ------------------------------------------------------------------
    logic [LW-1:0] norm_num;
    logic [LW-1:0] norm_den;

    assign norm_num = s3_num_reg << (PW'(LW - 1) - s3_pn_reg);
    assign norm_den = s3_den_reg << (PW'(LW - 1) - s3_pd_reg);

    // ------------------------------------------------------------------
    // Log2 fraction: one squaring per stage for each operand
    // ------------------------------------------------------------------
    logic                   lg_valid_reg [0:FB];
    ntcbt_pkg::force_t      lg_kind_reg  [0:FB];
    logic [MW-1:0]          lg_mn_reg    [0:FB];
    logic [MW-1:0]          lg_md_reg    [0:FB];
    logic [FB-1:0]          lg_fn_reg    [0:FB];
    logic [FB-1:0]          lg_fd_reg    [0:FB];
    logic [PW-1:0]          lg_pn_reg    [0:FB];
    logic [PW-1:0]          lg_pd_reg    [0:FB];

    logic [MW-1:0]          lg_mn_next   [1:FB];
    logic [MW-1:0]          lg_md_next   [1:FB];
    logic [FB-1:0]          lg_fn_next   [1:FB];
    logic [FB-1:0]          lg_fd_next   [1:FB];

    for (genvar k = 0; k < FB; k++)
    begin : g_log
        logic [2*MW-1:0] sq_num;
        logic [2*MW-1:0] sq_den;
        logic [MW:0]     t_num;
        logic [MW:0]     t_den;

        assign sq_num = (2*MW)'(lg_mn_reg[k]) * (2*MW)'(lg_mn_reg[k]);
        assign sq_den = (2*MW)'(lg_md_reg[k]) * (2*MW)'(lg_md_reg[k]);
        assign t_num  = sq_num[2*MW-1:MW-1];
        assign t_den  = sq_den[2*MW-1:MW-1];

        // Renormalize when the square reaches two
        assign lg_mn_next[k+1] = t_num[MW] ? t_num[MW:1] : t_num[MW-1:0];
        assign lg_md_next[k+1] = t_den[MW] ? t_den[MW:1] : t_den[MW-1:0];
        assign lg_fn_next[k+1] = {lg_fn_reg[k][FB-2:0], t_num[MW]};
        assign lg_fd_next[k+1] = {lg_fd_reg[k][FB-2:0], t_den[MW]};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lg_kind_reg[0] <= s3_kind_reg;
            lg_mn_reg[0]   <= norm_num[LW-1 -: MW];
            lg_md_reg[0]   <= norm_den[LW-1 -: MW];
            lg_fn_reg[0]   <= '0;
            lg_fd_reg[0]   <= '0;
            lg_pn_reg[0]   <= s3_pn_reg;
            lg_pd_reg[0]   <= s3_pd_reg;
            for (int k = 1; k <= FB; k++)
            begin
                lg_kind_reg[k] <= lg_kind_reg[k-1];
                lg_mn_reg[k]   <= lg_mn_next[k];
                lg_md_reg[k]   <= lg_md_next[k];
                lg_fn_reg[k]   <= lg_fn_next[k];
                lg_fd_reg[k]   <= lg_fd_next[k];
                lg_pn_reg[k]   <= lg_pn_reg[k-1];
                lg_pd_reg[k]   <= lg_pd_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Log difference, sign and magnitude
    // ------------------------------------------------------------------
    logic signed [MAG_W:0]  l2_diff;
    logic                   ln_valid_reg;
    ntcbt_pkg::force_t      ln_kind_reg;
    logic                   ln_neg_reg;
    logic [MAG_W-1:0]       ln_mag_reg;

    assign l2_diff = $signed({1'b0, lg_pn_reg[FB], lg_fn_reg[FB]})
                   - $signed({1'b0, lg_pd_reg[FB], lg_fd_reg[FB]});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ln_kind_reg <= lg_kind_reg[FB];
            ln_neg_reg  <= l2_diff[MAG_W];
            ln_mag_reg  <= l2_diff[MAG_W] ? MAG_W'(-l2_diff) : MAG_W'(l2_diff);
        end
    end

    // ------------------------------------------------------------------
    // Scale by ln(2), truncate to Q.24
    // ------------------------------------------------------------------
    logic [MAG_W+31:0]      lq_prod;
    logic                   lq_valid_reg;
    ntcbt_pkg::force_t      lq_kind_reg;
    logic                   lq_neg_reg;
    logic [MAG_W-1:0]       lq_ln_reg;

    assign lq_prod = (MAG_W+32)'(ln_mag_reg) * (MAG_W+32)'(ntcbt_pkg::LN2_Q32);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lq_kind_reg <= ln_kind_reg;
            lq_neg_reg  <= ln_neg_reg;
            lq_ln_reg   <= lq_prod[MAG_W+31:32];
        end
    end

    // ------------------------------------------------------------------
    // Divide ln by beta, rounded, one quotient bit per stage
    // ------------------------------------------------------------------
    logic                   dv_valid_reg [0:DVD_W];
    ntcbt_pkg::force_t      dv_kind_reg  [0:DVD_W];
    logic                   dv_neg_reg   [0:DVD_W];
    logic [DVD_W-1:0]       dv_dvd_reg   [0:DVD_W];
    logic [BW-1:0]          dv_rem_reg   [0:DVD_W];
    logic [DVD_W-1:0]       dv_q_reg     [0:DVD_W];

    logic [DVD_W-1:0]       dv_dvd_next  [1:DVD_W];
    logic [BW-1:0]          dv_rem_next  [1:DVD_W];
    logic [DVD_W-1:0]       dv_q_next    [1:DVD_W];

    for (genvar j = 0; j < DVD_W; j++)
    begin : g_beta_div
        logic [BW:0] r;
        logic        ge;

        assign r  = {dv_rem_reg[j], dv_dvd_reg[j][DVD_W-1]};
        assign ge = r >= {1'b0, beta_reg};
        assign dv_rem_next[j+1] = ge ? BW'(r - {1'b0, beta_reg}) : BW'(r);
        assign dv_dvd_next[j+1] = dv_dvd_reg[j] << 1;
        assign dv_q_next[j+1]   = {dv_q_reg[j][DVD_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_kind_reg[0] <= lq_kind_reg;
            dv_neg_reg[0]  <= lq_neg_reg;
            dv_dvd_reg[0]  <= DVD_W'({lq_ln_reg, 8'b0}) + DVD_W'(beta_reg[BW-1:1]);
            dv_rem_reg[0]  <= '0;
            dv_q_reg[0]    <= '0;
            for (int j = 1; j <= DVD_W; j++)
            begin
                dv_kind_reg[j] <= dv_kind_reg[j-1];
                dv_neg_reg[j]  <= dv_neg_reg[j-1];
                dv_dvd_reg[j]  <= dv_dvd_next[j];
                dv_rem_reg[j]  <= dv_rem_next[j];
                dv_q_reg[j]    <= dv_q_next[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Sum of reciprocals, check its sign
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] sm_term;
    logic signed [SUM_W-1:0] sm_sum;
    ntcbt_pkg::force_t       sm_kind_next;

    logic                    sm_valid_reg;
    ntcbt_pkg::force_t       sm_kind_reg;
    logic [DIVS_W-1:0]       sm_sum_reg;

    always_comb
    begin
        sm_term = signed'(SUM_W'(dv_q_reg[DVD_W]));
        if (dv_neg_reg[DVD_W])
            sm_term = -sm_term;
        sm_sum       = signed'(SUM_W'(rc_q_reg)) + sm_term;
        sm_kind_next = dv_kind_reg[DVD_W];
        if (dv_kind_reg[DVD_W] == ntcbt_pkg::FORCE_NONE)
        begin
            if (sm_sum == '0)
                sm_kind_next = ntcbt_pkg::FORCE_HIGH;
            else if (sm_sum[SUM_W-1])
                sm_kind_next = ntcbt_pkg::FORCE_LOW;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sm_kind_reg <= sm_kind_next;
            sm_sum_reg  <= sm_sum[DIVS_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Kelvin in thousandths: (1000 << 32 + sum/2) / sum, low 19 bits
    // ------------------------------------------------------------------
    logic [YD_W-1:0]        yd_num;

    logic                   yd_valid_reg [0:YB];
    ntcbt_pkg::force_t      yd_kind_reg  [0:YB];
    logic                   yd_over_reg  [0:YB];
    logic [DIVS_W-1:0]      yd_div_reg   [0:YB];
    logic [DIVS_W-1:0]      yd_rem_reg   [0:YB];
    logic [YB-1:0]          yd_dvd_reg   [0:YB];
    logic [YB-1:0]          yd_q_reg     [0:YB];

    logic [DIVS_W-1:0]      yd_rem_next  [1:YB];
    logic [YB-1:0]          yd_dvd_next  [1:YB];
    logic [YB-1:0]          yd_q_next    [1:YB];

    assign yd_num = YD_W'(ntcbt_pkg::Y_NUM) + YD_W'(sm_sum_reg[DIVS_W-1:1]);

    for (genvar j = 0; j < YB; j++)
    begin : g_kelvin_div
        logic [DIVS_W:0] r;
        logic            ge;

        assign r  = {yd_rem_reg[j], yd_dvd_reg[j][YB-1]};
        assign ge = r >= {1'b0, yd_div_reg[j]};
        assign yd_rem_next[j+1] = ge ? DIVS_W'(r - {1'b0, yd_div_reg[j]}) : DIVS_W'(r);
        assign yd_dvd_next[j+1] = yd_dvd_reg[j] << 1;
        assign yd_q_next[j+1]   = {yd_q_reg[j][YB-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Quotient of 2^19 or more is far above the high clamp
            yd_kind_reg[0] <= sm_kind_reg;
            yd_over_reg[0] <= (yd_num >> YB) >= YD_W'(sm_sum_reg);
            yd_div_reg[0]  <= sm_sum_reg;
            yd_rem_reg[0]  <= DIVS_W'(yd_num >> YB);
            yd_dvd_reg[0]  <= yd_num[YB-1:0];
            yd_q_reg[0]    <= '0;
            for (int j = 1; j <= YB; j++)
            begin
                yd_kind_reg[j] <= yd_kind_reg[j-1];
                yd_over_reg[j] <= yd_over_reg[j-1];
                yd_div_reg[j]  <= yd_div_reg[j-1];
                yd_rem_reg[j]  <= yd_rem_next[j];
                yd_dvd_reg[j]  <= yd_dvd_next[j];
                yd_q_reg[j]    <= yd_q_next[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Final stage: clamp, convert to Celsius tenths
    // ------------------------------------------------------------------
    logic [YB-1:0]                          fin_y;
    logic [ntcbt_pkg::X_W-1:0]              fin_x;
    logic [ntcbt_pkg::X_W+ntcbt_pkg::DIV100_MUL_W-1:0] fin_prod;
    logic [ntcbt_pkg::QT_W-1:0]             fin_qt;
    ntcbt_pkg::result_t                     pp_res_next;

    logic                                   pp_valid_reg;
    ntcbt_pkg::result_t                     pp_res_reg;

    always_comb
    begin
        fin_y    = yd_q_reg[YB];
        fin_x    = ntcbt_pkg::X_W'(fin_y - ntcbt_pkg::Y_BIAS);
        fin_prod = (ntcbt_pkg::X_W+ntcbt_pkg::DIV100_MUL_W)'(fin_x)
                 * (ntcbt_pkg::X_W+ntcbt_pkg::DIV100_MUL_W)'(ntcbt_pkg::DIV100_MUL);
        fin_qt   = fin_prod[ntcbt_pkg::X_W+ntcbt_pkg::DIV100_MUL_W-1:ntcbt_pkg::DIV100_SHIFT];

        pp_res_next.temp = ntcbt_pkg::TEMP_W'($signed({1'b0, fin_qt})
                         - ntcbt_pkg::TENTHS_BIAS);
        pp_res_next.lo   = 1'b0;
        pp_res_next.hi   = 1'b0;
        pp_res_next.inv  = 1'b0;

        case (yd_kind_reg[YB])
            ntcbt_pkg::FORCE_LOW:
            begin
                pp_res_next.temp = ntcbt_pkg::TEMP_LOW;
                pp_res_next.lo   = 1'b1;
            end
            ntcbt_pkg::FORCE_HIGH:
            begin
                pp_res_next.temp = ntcbt_pkg::TEMP_HIGH;
                pp_res_next.hi   = 1'b1;
            end
            ntcbt_pkg::FORCE_INVALID:
            begin
                pp_res_next.temp = ntcbt_pkg::TEMP_LOW;
                pp_res_next.inv  = 1'b1;
            end
            default:
            begin
                if (yd_over_reg[YB] || fin_y > ntcbt_pkg::Y_HIGH)
                begin
                    pp_res_next.temp = ntcbt_pkg::TEMP_HIGH;
                    pp_res_next.hi   = 1'b1;
                end
                else if (fin_y < ntcbt_pkg::Y_LOW)
                begin
                    pp_res_next.temp = ntcbt_pkg::TEMP_LOW;
                    pp_res_next.lo   = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            pp_res_reg <= pp_res_next;
    end

    // ------------------------------------------------------------------
    // Valid bits travel with the data
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            ln_valid_reg <= 1'b0;
            lq_valid_reg <= 1'b0;
            sm_valid_reg <= 1'b0;
            pp_valid_reg <= 1'b0;
            for (int k = 0; k <= FB; k++)
                lg_valid_reg[k] <= 1'b0;
            for (int j = 0; j <= DVD_W; j++)
                dv_valid_reg[j] <= 1'b0;
            for (int j = 0; j <= YB; j++)
                yd_valid_reg[j] <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg    <= in_take;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            lg_valid_reg[0] <= s3_valid_reg;
            for (int k = 1; k <= FB; k++)
                lg_valid_reg[k] <= lg_valid_reg[k-1];
            ln_valid_reg    <= lg_valid_reg[FB];
            lq_valid_reg    <= ln_valid_reg;
            dv_valid_reg[0] <= lq_valid_reg;
            for (int j = 1; j <= DVD_W; j++)
                dv_valid_reg[j] <= dv_valid_reg[j-1];
            sm_valid_reg    <= dv_valid_reg[DVD_W];
            yd_valid_reg[0] <= sm_valid_reg;
            for (int j = 1; j <= YB; j++)
                yd_valid_reg[j] <= yd_valid_reg[j-1];
            pp_valid_reg    <= yd_valid_reg[YB];
        end
    end

    // ------------------------------------------------------------------
    // Output register with one skid entry
    // ------------------------------------------------------------------
    logic                   out_valid_reg, out_valid_next;
    ntcbt_pkg::result_t     out_res_reg, out_res_next;
    ntcbt_pkg::result_t     skid_res_reg, skid_res_next;
    logic                   out_take;

    always_comb
    begin
        out_take       = out_valid_reg && !out_stall;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        skid_full_next = skid_full_reg;
        skid_res_next  = skid_res_reg;
        if (skid_full_reg)
        begin
            // Drain the skid entry first
            if (out_take)
            begin
                out_res_next   = skid_res_reg;
                skid_full_next = 1'b0;
            end
        end
        else if (pp_valid_reg)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_res_next   = pp_res_reg;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_res_next  = pp_res_reg;
                skid_full_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign out_valid       = out_valid_reg;
    assign temp_tenths     = out_res_reg.temp;
    assign clamped_low     = out_res_reg.lo;
    assign clamped_high    = out_res_reg.hi;
    assign invalid_divider = out_res_reg.inv;

`ifndef NO_ASSERTIONS
    // A skid entry is only taken when the output register is occupied
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid entry held without an output beat");

    // At most one outcome flag per beat
    a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({clamped_low, clamped_high, invalid_divider}))
        else $error("more than one outcome flag set");

    // High clamp always reads 85.0 C
    a_high_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clamped_high) |-> (temp_tenths == ntcbt_pkg::TEMP_HIGH))
        else $error("high clamp with wrong temperature");

    // Unflagged results stay inside the range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !clamped_low && !clamped_high && !invalid_divider)
        |-> (temp_tenths >= ntcbt_pkg::TEMP_LOW && temp_tenths <= ntcbt_pkg::TEMP_HIGH))
        else $error("temperature out of range");

    // Reference reciprocal is never zero once formed
    a_recip_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(rc_busy) |-> (rc_q_reg != '0))
        else $error("reference reciprocal is zero");
`endif

endmodule
